@@ rtl/tcw_pkg.sv @@
package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int SCREEN  = COLUMNS * ROWS;
  localparam int STORE   = 2 * SCREEN;

  // Field widths of the transaction payloads.
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int LIN_W  = 11;
  localparam int BASE_W = 11;
  localparam int CELL_W = 2 * CHAR_W;

  // Cell store addressing and sweep counting.
  localparam int ADDR_W = $clog2(STORE);
  localparam int CNT_W  = $clog2(STORE + 1);

  // Offsets used by scrolling.
  localparam int BOTTOM   = (ROWS - 1) * COLUMNS;
  localparam int COPY_SRC = SCREEN + COLUMNS;
  localparam int COPY_LEN = (ROWS - 1) * COLUMNS;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SETCUR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  // Character codes with special handling.
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h07;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [LIN_W-1:0]  cursor_linear;
    logic [BASE_W-1:0] view_base;
    logic [CHAR_W-1:0] read_char;
    logic [CHAR_W-1:0] read_attr;
  } out_item_t;

  // Follow-up work that an accepted command needs.
  typedef enum logic [1:0] {
    WORK_NONE,
    WORK_BS,
    WORK_COPY,
    WORK_BLANK
  } work_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_BS,
    ST_COPY,
    ST_COPY_TAIL,
    ST_BLANK,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic bs_wr;
    logic copy_step;
    logic blank_step;
    logic init_step;
    logic out_load;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    work_t work;
    logic  last;
    logic  out_free;
  } stat_t;

  // Cell offset of the first cell of a 1-based row.
  function automatic logic [ADDR_W-1:0] row_offset(input logic [ROW_W-1:0] y);
    logic [ADDR_W-1:0] r;
    r = ADDR_W'(y - ROW_W'(1));
    return ADDR_W'(r * ADDR_W'(COLUMNS));
  endfunction

  // Store address of a 1-based cell inside the window.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [BASE_W-1:0] base,
                                                  input logic [COL_W-1:0]  x,
                                                  input logic [ROW_W-1:0]  y);
    return ADDR_W'(base) + row_offset(y) + ADDR_W'(x - COL_W'(1));
  endfunction

endpackage

@@ rtl/tcw_ctrl.sv @@
module tcw_ctrl import tcw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output ctl_t  ctl
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_INIT: begin
        ctl.init_step = 1'b1;
        if (stat.last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.accept = 1'b1;
          unique case (stat.work)
            WORK_NONE:  state_next = ST_DONE;
            WORK_BS:    state_next = ST_BS;
            WORK_COPY:  state_next = ST_COPY;
            WORK_BLANK: state_next = ST_BLANK;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_BS: begin
        ctl.bs_wr  = 1'b1;
        state_next = ST_DONE;
      end
      ST_COPY: begin
        ctl.copy_step = 1'b1;
        if (stat.last) begin
          state_next = ST_COPY_TAIL;
        end
      end
      // The last copied cell is written back during this cycle.
      ST_COPY_TAIL: begin
        state_next = ST_BLANK;
      end
      ST_BLANK: begin
        ctl.blank_step = 1'b1;
        if (stat.last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

@@ rtl/tcw_datapath.sv @@
module tcw_datapath import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  in_item_t          in_item,
  input  logic              cfg_wen,
  input  logic [CHAR_W-1:0] cfg_data,
  input  ctl_t              ctl,
  output stat_t             stat,
  input  logic              out_stall,
  output logic              out_valid,
  output out_item_t         out_item
);

  logic [CELL_W-1:0] mem [STORE];

  logic [COL_W-1:0]  cursor_x;
  logic [ROW_W-1:0]  cursor_y;
  logic [BASE_W-1:0] base;
  logic [CHAR_W-1:0] char_attr;
  logic [CNT_W-1:0]  sweep_addr;
  logic [CNT_W-1:0]  sweep_cnt;
  logic              is_read;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  logic [CELL_W-1:0] rdata;

  logic [COL_W-1:0]  x_next;
  logic [ROW_W-1:0]  y_next;
  logic [BASE_W-1:0] base_next;
  logic [CNT_W-1:0]  start_addr;
  logic [CNT_W-1:0]  start_cnt;
  work_t             work;
  logic              put_wr;
  logic              rd_req;
  logic              adv;
  logic              lf;
  logic              scroll;
  logic [COL_W-1:0]  col_c;
  logic [ROW_W-1:0]  row_c;

  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] rd_addr_in;
  logic [CNT_W-1:0]  copy_src;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] blank_cell;
  logic [LIN_W-1:0]  linear;

  // Clamp the requested coordinates to the screen.
  always_comb begin
    if (in_item.col == '0) begin
      col_c = COL_W'(1);
    end else if (in_item.col > COL_W'(COLUMNS)) begin
      col_c = COL_W'(COLUMNS);
    end else begin
      col_c = in_item.col;
    end
    if (in_item.row == '0) begin
      row_c = ROW_W'(1);
    end else if (in_item.row > ROW_W'(ROWS)) begin
      row_c = ROW_W'(ROWS);
    end else begin
      row_c = in_item.row;
    end
  end

  // Effect of the incoming transaction on cursor, window and follow-up work.
  always_comb begin
    x_next     = cursor_x;
    y_next     = cursor_y;
    base_next  = base;
    work       = WORK_NONE;
    put_wr     = 1'b0;
    rd_req     = 1'b0;
    adv        = 1'b0;
    lf         = 1'b0;
    scroll     = 1'b0;
    start_addr = '0;
    start_cnt  = '0;
    unique case (in_item.cmd)
      CMD_PUT: begin
        if (in_item.char_code == CH_BS) begin
          work = WORK_BS;
          if (cursor_x > COL_W'(1)) begin
            x_next = cursor_x - COL_W'(1);
          end else if (cursor_y > ROW_W'(1)) begin
            x_next = COL_W'(COLUMNS);
            y_next = cursor_y - ROW_W'(1);
          end
        end else if (in_item.char_code == CH_TAB) begin
          adv = 1'b1;
        end else if (in_item.char_code == CH_LF) begin
          x_next = COL_W'(1);
          lf     = 1'b1;
        end else if (in_item.char_code == CH_CR) begin
          x_next = COL_W'(1);
        end else if (in_item.char_code >= CH_SPACE && in_item.char_code != CH_ESC) begin
          put_wr = 1'b1;
          adv    = 1'b1;
        end
        // Advance one column, wrapping into a line feed.
        if (adv) begin
          if (cursor_x < COL_W'(COLUMNS)) begin
            x_next = cursor_x + COL_W'(1);
          end else begin
            x_next = COL_W'(1);
            lf     = 1'b1;
          end
        end
        // Line feed on the last row scrolls the window.
        if (lf) begin
          if (cursor_y < ROW_W'(ROWS)) begin
            y_next = cursor_y + ROW_W'(1);
          end else begin
            scroll = 1'b1;
          end
        end
        if (scroll) begin
          if (base < BASE_W'(SCREEN)) begin
            base_next  = base + BASE_W'(COLUMNS);
            work       = WORK_BLANK;
            start_addr = CNT_W'(base) + CNT_W'(COLUMNS + BOTTOM);
            start_cnt  = CNT_W'(COLUMNS);
          end else begin
            base_next  = '0;
            work       = WORK_COPY;
            start_addr = '0;
            start_cnt  = CNT_W'(COPY_LEN);
          end
        end
      end
      CMD_SETCUR: begin
        x_next = col_c;
        y_next = row_c;
      end
      CMD_CLEAR: begin
        x_next     = COL_W'(1);
        y_next     = ROW_W'(1);
        work       = WORK_BLANK;
        start_addr = CNT_W'(base);
        start_cnt  = CNT_W'(SCREEN);
      end
      CMD_READ: begin
        rd_req = 1'b1;
      end
      default: begin
        work = WORK_NONE;
      end
    endcase
  end

  assign cur_addr   = cell_addr(base, cursor_x, cursor_y);
  assign rd_addr_in = cell_addr(base, col_c, row_c);
  assign copy_src   = sweep_addr + CNT_W'(COPY_SRC);
  assign blank_cell = {char_attr, CH_SPACE};

  // Write port: a pending copy write has the port to itself.
  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = blank_cell;
    priority if (pend) begin
      we    = 1'b1;
      waddr = pend_addr;
      wdata = rdata;
    end else if (ctl.init_step) begin
      we    = 1'b1;
      waddr = sweep_addr[ADDR_W-1:0];
      wdata = '0;
    end else if (ctl.blank_step) begin
      we    = 1'b1;
      waddr = sweep_addr[ADDR_W-1:0];
    end else if (ctl.bs_wr) begin
      we = 1'b1;
    end else if (ctl.accept && put_wr) begin
      we    = 1'b1;
      wdata = {char_attr, in_item.char_code};
    end else begin
      we = 1'b0;
    end
  end

  // Read port: copy source or the addressed cell of a read transaction.
  assign re    = ctl.copy_step | (ctl.accept & rd_req);
  assign raddr = ctl.copy_step ? copy_src[ADDR_W-1:0] : rd_addr_in;

  // Cell store.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Copy write-back happens in the cycle after each copy read.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= ctl.copy_step;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= sweep_addr[ADDR_W-1:0];
  end

  // Sweep address and remaining count for initial zeroing, clearing, blanking and copying.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      sweep_cnt  <= CNT_W'(STORE);
    end else if (ctl.accept && (work == WORK_BLANK || work == WORK_COPY)) begin
      sweep_addr <= start_addr;
      sweep_cnt  <= start_cnt;
    end else if (ctl.copy_step) begin
      // After the copy the address already points at the new bottom row.
      sweep_addr <= sweep_addr + CNT_W'(1);
      sweep_cnt  <= stat.last ? CNT_W'(COLUMNS) : sweep_cnt - CNT_W'(1);
    end else if (ctl.blank_step || ctl.init_step) begin
      sweep_addr <= sweep_addr + CNT_W'(1);
      sweep_cnt  <= sweep_cnt - CNT_W'(1);
    end
  end

  // Cursor and window base.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= COL_W'(1);
      cursor_y <= ROW_W'(1);
      base     <= '0;
      is_read  <= 1'b0;
    end else if (ctl.accept) begin
      cursor_x <= x_next;
      cursor_y <= y_next;
      base     <= base_next;
      is_read  <= rd_req;
    end
  end

  // Attribute register.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_attr <= ATTR_RESET;
    end else if (cfg_wen) begin
      char_attr <= cfg_data;
    end
  end

  assign linear = LIN_W'(row_offset(cursor_y)) + LIN_W'(cursor_x - COL_W'(1));

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_item.cursor_col    <= cursor_x;
      out_item.cursor_row    <= cursor_y;
      out_item.cursor_linear <= linear;
      out_item.view_base     <= base;
      out_item.read_char     <= is_read ? rdata[CHAR_W-1:0] : '0;
      out_item.read_attr     <= is_read ? rdata[CELL_W-1:CHAR_W] : '0;
    end
  end

  assign stat.work     = work;
  assign stat.last     = (sweep_cnt == CNT_W'(1));
  assign stat.out_free = !out_valid || !out_stall;

endmodule

@@ rtl/text_console_writer.sv @@
// Put, set cursor and read go from ST_IDLE to ST_DONE, where the result is loaded; backspace first
// writes a blank in ST_BS. A scroll blanks a row of cells (80); at the store end it first copies 24 rows,
// one cell a cycle (1920 cells). Clear blanks every screen cell (2000).
// No new transaction is taken until the result of the previous one is loaded into the output register.
// Reset is synchronous; afterwards a pass zeroes the cell store (4000 cells) with in_stall high.
module text_console_writer import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_wen,
  input  logic [CHAR_W-1:0] cfg_data
);

  ctl_t  ctl;
  stat_t stat;

  // Sequencing of commands and row sweeps.
  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Cursor, window, cell store and output register.
  tcw_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_wen   (cfg_wen),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
